FILE: design/rmss_pkg.sv
// Package for the ROI mean, standard deviation and SNR engine.
// Holds the shared widths, reset values, register indexes, state codes and
// the control and status types between the sequencer and the divide/root unit.
package rmss_pkg;

   localparam int DIM_BITS_DEF = 9;

   localparam int VOXEL_W = 18;
   localparam int VSQ_W = 2 * VOXEL_W;
   localparam int CFG_SIZE_W = 10;
   localparam int RADIUS_W = 20;
   localparam int Z_W = 12;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W = 3;

   localparam int COUNT_W = 28;
   localparam int SUM_W = 46;
   localparam int SQS_W = 62;

   localparam int MEAN_W = 18;
   localparam int SD_W = 17;
   localparam int SNR_W = 20;
   localparam int SNR_FRAC = 8;

   localparam int MUL_W = 29;
   localparam int PROD_W = 2 * MUL_W;
   localparam int WIDE_W = 64;
   localparam int M_W = 46;
   localparam int M_LO_W = 23;
   localparam int VAR_W = 36;
   localparam int ROOT_W = 18;
   localparam int QM_W = 18;
   localparam int SNR_MAG_W = 27;

   localparam int REM_W = 30;
   localparam int DIV_STEPS = 64;
   localparam int SQRT_STEPS = VAR_W / 2;
   localparam int STEP_CNT_W = 7;

   localparam logic [CFG_SIZE_W-1:0] X_SIZE_RST = 10'd100;
   localparam logic [CFG_SIZE_W-1:0] Y_SIZE_RST = 10'd100;
   localparam logic [CFG_SIZE_W-1:0] Z_SIZE_RST = 10'd275;
   localparam logic [RADIUS_W-1:0] RADIUS_SQ_RST = 20'd3164;
   localparam logic signed [Z_W-1:0] Z_LOW_RST = -12'sd5;
   localparam logic signed [Z_W-1:0] Z_HIGH_RST = 12'sd45;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 28'h8000000;
   localparam logic [SNR_MAG_W-1:0] SNR_POS_LIMIT = 27'd524287;
   localparam logic [SNR_MAG_W-1:0] SNR_NEG_LIMIT = 27'd524288;
   localparam logic signed [SNR_W-1:0] SNR_MAX = 20'sd524287;
   localparam logic signed [SNR_W-1:0] SNR_MIN = -20'sd524288;

   localparam logic [CSR_IDX_W-1:0] CSR_X_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_SIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQ = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_LOW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_HIGH = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_Y,
      ST_SQ_V,
      ST_UPDATE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_T_ACC,
      ST_T_SUB,
      ST_VAR_GO,
      ST_VAR_WAIT,
      ST_MUL_BC,
      ST_MUL_RR,
      ST_VAR_FIX,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_SNR_GO,
      ST_SNR_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic {
      OP_DIV,
      OP_SQRT
   } iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_stat_type;

endpackage

FILE: design/rmss_iter.sv
// Radix-2 unsigned divider and integer square root sharing one compare and subtract.
// Depends on rmss_pkg for widths, step counts and the control and status types.
module rmss_iter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmss_pkg::iter_ctrl_type              ctrl,
   input  logic [rmss_pkg::WIDE_W-1:0]          dividend,
   input  logic [rmss_pkg::COUNT_W-1:0]         divisor,
   output rmss_pkg::iter_stat_type              stat,
   output logic [rmss_pkg::WIDE_W-1:0]          quot,
   output logic [rmss_pkg::COUNT_W-1:0]         rem
);

   logic [rmss_pkg::WIDE_W-1:0]     acc_ff, acc_in;
   logic [rmss_pkg::WIDE_W-1:0]     quot_ff, quot_in;
   logic [rmss_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [rmss_pkg::COUNT_W-1:0]    div_ff, div_in;
   logic [rmss_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;
   rmss_pkg::iter_op_type           op_ff, op_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [rmss_pkg::REM_W-1:0]      part;
   logic [rmss_pkg::REM_W-1:0]      trial;
   logic                            fits;

   always_comb begin
      if (op_ff == rmss_pkg::OP_SQRT) begin
         part = {rem_ff[rmss_pkg::REM_W-3:0], acc_ff[rmss_pkg::WIDE_W-1 -: 2]};
         trial = {quot_ff[rmss_pkg::REM_W-3:0], 2'b01};
      end else begin
         part = {rem_ff[rmss_pkg::REM_W-2:0], acc_ff[rmss_pkg::WIDE_W-1]};
         trial = rmss_pkg::REM_W'(div_ff);
      end
      fits = (part >= trial);
   end

   always_comb begin
      acc_in = acc_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      op_in = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in = fits ? (part - trial) : part;
         quot_in = {quot_ff[rmss_pkg::WIDE_W-2:0], fits};
         if (op_ff == rmss_pkg::OP_SQRT) begin
            acc_in = {acc_ff[rmss_pkg::WIDE_W-3:0], 2'b00};
         end else begin
            acc_in = {acc_ff[rmss_pkg::WIDE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - rmss_pkg::STEP_CNT_W'(1);
         if (cnt_ff == rmss_pkg::STEP_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctrl.start) begin
         busy_in = 1'b1;
         op_in = ctrl.op;
         div_in = divisor;
         rem_in = '0;
         quot_in = '0;
         if (ctrl.op == rmss_pkg::OP_SQRT) begin
            acc_in = {dividend[rmss_pkg::VAR_W-1:0],
                      {(rmss_pkg::WIDE_W - rmss_pkg::VAR_W){1'b0}}};
            cnt_in = rmss_pkg::STEP_CNT_W'(rmss_pkg::SQRT_STEPS);
         end else begin
            acc_in = dividend;
            cnt_in = rmss_pkg::STEP_CNT_W'(rmss_pkg::DIV_STEPS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
         op_ff <= rmss_pkg::OP_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
         op_ff <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot = quot_ff;
   assign rem = rem_ff[rmss_pkg::COUNT_W-1:0];

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divide/root unit reports done while still busy");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> cnt_ff != '0)
      else $error("divide/root unit busy with no steps left");
`endif

endmodule

FILE: design/roi_mean_sd_snr_engine.sv
// Top level of the ROI mean, standard deviation and SNR engine.
// Depends on rmss_pkg and instantiates the divide/root unit rmss_iter.
//
// Voxels arrive one per transaction in x, y, z raster order; the block tracks the
// position itself. After start, busy stays high while each voxel passes through
// SQ_Y, SQ_V and UPDATE, because one shared multiplier forms the x and y center
// squares and the voxel square in turn. After the last voxel of a volume the block
// stays busy while the radix-2 divide/root unit runs up to three 64-step divisions
// and an 18-step square root (the last division, for the SNR, is skipped when the
// root is zero); an empty ROI skips this. The result is shown for exactly one
// cycle on rsp_strobe and cannot be held off, so the receiver must take it then.
module roi_mean_sd_snr_engine #(
   parameter int DIM_BITS = rmss_pkg::DIM_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_wr_en,
   input  logic [rmss_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [rmss_pkg::CSR_DATA_W-1:0]            csr_wdata,
   input  logic                                       start,
   output logic                                       busy,
   input  logic signed [rmss_pkg::VOXEL_W-1:0]        req_voxel_value,
   output logic                                       rsp_strobe,
   output logic signed [rmss_pkg::MEAN_W-1:0]         rsp_mean_value,
   output logic [rmss_pkg::SD_W-1:0]                  rsp_std_dev,
   output logic signed [rmss_pkg::SNR_W-1:0]          rsp_snr_value,
   output logic [rmss_pkg::COUNT_W-1:0]               rsp_roi_voxels,
   output logic                                       rsp_roi_empty,
   output logic                                       rsp_sd_zero
);

   localparam int POS_W = DIM_BITS;
   localparam int SIZE_W = DIM_BITS + 1;
   localparam int CTR_W = DIM_BITS + 2;
   localparam int SQ_W = 2 * DIM_BITS + 2;
   localparam int DIST_W = SQ_W + 1;
   localparam int CMP_W = (DIST_W > rmss_pkg::RADIUS_W) ? DIST_W : rmss_pkg::RADIUS_W;
   localparam int ZC_W = (CTR_W > rmss_pkg::Z_W) ? CTR_W : rmss_pkg::Z_W;
   localparam int DIM_MAX = 1 << DIM_BITS;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [rmss_pkg::CFG_SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      if (s == '0) begin
         r = SIZE_W'(1);
      end else if (s > rmss_pkg::CFG_SIZE_W'(DIM_MAX)) begin
         r = SIZE_W'(DIM_MAX);
      end else begin
         r = SIZE_W'(s);
      end
      return r;
   endfunction

   function automatic logic signed [CTR_W-1:0] center(input logic [POS_W-1:0] pos,
                                                      input logic [SIZE_W-1:0] size);
      logic [CTR_W-1:0] a;
      logic [CTR_W-1:0] b;
      a = {1'b0, pos, 1'b1};
      b = {1'b0, size[SIZE_W-1:1], 1'b0};
      return signed'(a - b);
   endfunction

   // Configuration registers.
   logic [rmss_pkg::CFG_SIZE_W-1:0]   x_size_ff, y_size_ff, z_size_ff;
   logic [rmss_pkg::RADIUS_W-1:0]     radius_sq_ff;
   logic signed [rmss_pkg::Z_W-1:0]   z_low_ff, z_high_ff;

   // Control and accumulator state.
   rmss_pkg::state_type               state_ff, state_in;
   logic [POS_W-1:0]                  x_pos_ff, x_pos_in;
   logic [POS_W-1:0]                  y_pos_ff, y_pos_in;
   logic [POS_W-1:0]                  z_pos_ff, z_pos_in;
   logic [rmss_pkg::COUNT_W-1:0]      roi_count_ff, roi_count_in;
   logic signed [rmss_pkg::SUM_W-1:0] value_sum_ff, value_sum_in;
   logic [rmss_pkg::SQS_W-1:0]        square_sum_ff, square_sum_in;
   logic                              strobe_ff, strobe_in;

   // Datapath registers.
   logic signed [rmss_pkg::VOXEL_W-1:0] voxel_ff, voxel_in;
   logic signed [rmss_pkg::PROD_W-1:0]  mul_ff;
   logic [DIST_W-1:0]                   dist_ff, dist_in;
   logic [rmss_pkg::QM_W-1:0]           qm_ff, qm_in;
   logic [rmss_pkg::COUNT_W-1:0]        rm_ff, rm_in;
   logic [rmss_pkg::M_W-1:0]            m_ff, m_in;
   logic [rmss_pkg::WIDE_W-1:0]         prod_ff, prod_in;
   logic [rmss_pkg::VAR_W-1:0]          a_ff, a_in;
   logic [rmss_pkg::COUNT_W-1:0]        b_ff, b_in;
   logic [rmss_pkg::ROOT_W-1:0]         sd_ff, sd_in;
   logic signed [rmss_pkg::SNR_W-1:0]   snr_ff, snr_in;

   logic signed [rmss_pkg::MEAN_W-1:0]  out_mean_ff, out_mean_in;
   logic [rmss_pkg::SD_W-1:0]           out_sd_ff, out_sd_in;
   logic signed [rmss_pkg::SNR_W-1:0]   out_snr_ff, out_snr_in;
   logic [rmss_pkg::COUNT_W-1:0]        out_count_ff, out_count_in;
   logic                                out_empty_ff, out_empty_in;
   logic                                out_sdz_ff, out_sdz_in;

   // Shared multiplier.
   logic signed [rmss_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [rmss_pkg::PROD_W-1:0]  mul_p;

   // Divide/root unit.
   rmss_pkg::iter_ctrl_type             iter_ctrl;
   rmss_pkg::iter_stat_type             iter_stat;
   logic [rmss_pkg::WIDE_W-1:0]         iter_dividend;
   logic [rmss_pkg::COUNT_W-1:0]        iter_divisor;
   logic [rmss_pkg::WIDE_W-1:0]         iter_quot;
   logic [rmss_pkg::COUNT_W-1:0]        iter_rem;

   // Position helpers.
   logic [SIZE_W-1:0]                   x_eff, y_eff, z_eff;
   logic signed [CTR_W-1:0]             cx, cy, cz;
   logic                                last_x, last_y, last_z;
   logic                                in_roi;
   logic                                vs_neg;
   logic [rmss_pkg::M_W-1:0]            vs_mag;
   logic [rmss_pkg::SNR_MAG_W-1:0]      snr_mag;
   logic                                roi_none;

   assign x_eff = eff_size(x_size_ff);
   assign y_eff = eff_size(y_size_ff);
   assign z_eff = eff_size(z_size_ff);
   assign cx = center(x_pos_ff, x_eff);
   assign cy = center(y_pos_ff, y_eff);
   assign cz = center(z_pos_ff, z_eff);
   assign last_x = ({1'b0, x_pos_ff} + SIZE_W'(1)) >= x_eff;
   assign last_y = ({1'b0, y_pos_ff} + SIZE_W'(1)) >= y_eff;
   assign last_z = ({1'b0, z_pos_ff} + SIZE_W'(1)) >= z_eff;

   assign in_roi = (CMP_W'(dist_ff) <= CMP_W'(radius_sq_ff))
                   && (ZC_W'(cz) >= ZC_W'(z_low_ff))
                   && (ZC_W'(cz) <= ZC_W'(z_high_ff))
                   && (roi_count_ff < rmss_pkg::COUNT_LIMIT);

   assign vs_neg = value_sum_ff[rmss_pkg::SUM_W-1];
   assign vs_mag = vs_neg ? rmss_pkg::M_W'(-value_sum_ff) : rmss_pkg::M_W'(value_sum_ff);
   assign snr_mag = iter_quot[rmss_pkg::SNR_MAG_W-1:0];
   assign roi_none = (roi_count_ff == '0);

   assign busy = (state_ff != rmss_pkg::ST_IDLE);

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         rmss_pkg::ST_IDLE: begin
            mul_a = rmss_pkg::MUL_W'(cx);
            mul_b = rmss_pkg::MUL_W'(cx);
         end
         rmss_pkg::ST_SQ_Y: begin
            mul_a = rmss_pkg::MUL_W'(cy);
            mul_b = rmss_pkg::MUL_W'(cy);
         end
         rmss_pkg::ST_SQ_V: begin
            mul_a = rmss_pkg::MUL_W'(voxel_ff);
            mul_b = rmss_pkg::MUL_W'(voxel_ff);
         end
         rmss_pkg::ST_MUL_LO: begin
            mul_a = signed'(rmss_pkg::MUL_W'(qm_ff));
            mul_b = signed'(rmss_pkg::MUL_W'(m_ff[rmss_pkg::M_LO_W-1:0]));
         end
         rmss_pkg::ST_MUL_HI: begin
            mul_a = signed'(rmss_pkg::MUL_W'(qm_ff));
            mul_b = signed'(rmss_pkg::MUL_W'(m_ff[rmss_pkg::M_W-1:rmss_pkg::M_LO_W]));
         end
         rmss_pkg::ST_MUL_BC: begin
            mul_a = signed'(rmss_pkg::MUL_W'(b_ff));
            mul_b = signed'(rmss_pkg::MUL_W'(roi_count_ff));
         end
         rmss_pkg::ST_MUL_RR: begin
            mul_a = signed'(rmss_pkg::MUL_W'(rm_ff));
            mul_b = signed'(rmss_pkg::MUL_W'(rm_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in = state_ff;
      x_pos_in = x_pos_ff;
      y_pos_in = y_pos_ff;
      z_pos_in = z_pos_ff;
      roi_count_in = roi_count_ff;
      value_sum_in = value_sum_ff;
      square_sum_in = square_sum_ff;
      strobe_in = 1'b0;
      voxel_in = voxel_ff;
      dist_in = dist_ff;
      qm_in = qm_ff;
      rm_in = rm_ff;
      m_in = m_ff;
      prod_in = prod_ff;
      a_in = a_ff;
      b_in = b_ff;
      sd_in = sd_ff;
      snr_in = snr_ff;
      out_mean_in = out_mean_ff;
      out_sd_in = out_sd_ff;
      out_snr_in = out_snr_ff;
      out_count_in = out_count_ff;
      out_empty_in = out_empty_ff;
      out_sdz_in = out_sdz_ff;
      iter_ctrl.start = 1'b0;
      iter_ctrl.op = rmss_pkg::OP_DIV;
      iter_dividend = '0;
      iter_divisor = roi_count_ff;

      unique case (state_ff)
         rmss_pkg::ST_IDLE: begin
            if (start) begin
               voxel_in = req_voxel_value;
               state_in = rmss_pkg::ST_SQ_Y;
            end
         end
         rmss_pkg::ST_SQ_Y: begin
            dist_in = DIST_W'(mul_ff[SQ_W-1:0]);
            state_in = rmss_pkg::ST_SQ_V;
         end
         rmss_pkg::ST_SQ_V: begin
            dist_in = dist_ff + DIST_W'(mul_ff[SQ_W-1:0]);
            state_in = rmss_pkg::ST_UPDATE;
         end
         rmss_pkg::ST_UPDATE: begin
            if (in_roi) begin
               roi_count_in = roi_count_ff + rmss_pkg::COUNT_W'(1);
               value_sum_in = value_sum_ff + rmss_pkg::SUM_W'(voxel_ff);
               square_sum_in = square_sum_ff
                               + rmss_pkg::SQS_W'(mul_ff[rmss_pkg::VSQ_W-1:0]);
            end
            state_in = rmss_pkg::ST_IDLE;
            if (!last_x) begin
               x_pos_in = x_pos_ff + POS_W'(1);
            end else begin
               x_pos_in = '0;
               if (!last_y) begin
                  y_pos_in = y_pos_ff + POS_W'(1);
               end else begin
                  y_pos_in = '0;
                  if (!last_z) begin
                     z_pos_in = z_pos_ff + POS_W'(1);
                  end else begin
                     z_pos_in = '0;
                     state_in = rmss_pkg::ST_MEAN_GO;
                  end
               end
            end
         end
         rmss_pkg::ST_MEAN_GO: begin
            if (roi_none) begin
               state_in = rmss_pkg::ST_EMIT;
            end else begin
               iter_ctrl.start = 1'b1;
               iter_dividend = rmss_pkg::WIDE_W'(vs_mag);
               state_in = rmss_pkg::ST_MEAN_WAIT;
            end
         end
         rmss_pkg::ST_MEAN_WAIT: begin
            if (iter_stat.done) begin
               qm_in = iter_quot[rmss_pkg::QM_W-1:0];
               rm_in = iter_rem;
               m_in = vs_mag + rmss_pkg::M_W'(iter_rem);
               state_in = rmss_pkg::ST_MUL_LO;
            end
         end
         rmss_pkg::ST_MUL_LO: begin
            state_in = rmss_pkg::ST_MUL_HI;
         end
         rmss_pkg::ST_MUL_HI: begin
            prod_in = rmss_pkg::WIDE_W'(unsigned'(mul_ff));
            state_in = rmss_pkg::ST_T_ACC;
         end
         rmss_pkg::ST_T_ACC: begin
            prod_in = prod_ff + {mul_ff[rmss_pkg::WIDE_W-rmss_pkg::M_LO_W-1:0],
                                 {rmss_pkg::M_LO_W{1'b0}}};
            state_in = rmss_pkg::ST_T_SUB;
         end
         rmss_pkg::ST_T_SUB: begin
            prod_in = rmss_pkg::WIDE_W'(square_sum_ff) - prod_ff;
            state_in = rmss_pkg::ST_VAR_GO;
         end
         rmss_pkg::ST_VAR_GO: begin
            iter_ctrl.start = 1'b1;
            iter_dividend = prod_ff;
            state_in = rmss_pkg::ST_VAR_WAIT;
         end
         rmss_pkg::ST_VAR_WAIT: begin
            if (iter_stat.done) begin
               a_in = iter_quot[rmss_pkg::VAR_W-1:0];
               b_in = iter_rem;
               state_in = rmss_pkg::ST_MUL_BC;
            end
         end
         rmss_pkg::ST_MUL_BC: begin
            state_in = rmss_pkg::ST_MUL_RR;
         end
         rmss_pkg::ST_MUL_RR: begin
            prod_in = rmss_pkg::WIDE_W'(unsigned'(mul_ff));
            state_in = rmss_pkg::ST_VAR_FIX;
         end
         rmss_pkg::ST_VAR_FIX: begin
            if (prod_ff < rmss_pkg::WIDE_W'(unsigned'(mul_ff))) begin
               a_in = (a_ff == '0) ? '0 : (a_ff - rmss_pkg::VAR_W'(1));
            end
            state_in = rmss_pkg::ST_SQRT_GO;
         end
         rmss_pkg::ST_SQRT_GO: begin
            iter_ctrl.start = 1'b1;
            iter_ctrl.op = rmss_pkg::OP_SQRT;
            iter_dividend = rmss_pkg::WIDE_W'(a_ff);
            state_in = rmss_pkg::ST_SQRT_WAIT;
         end
         rmss_pkg::ST_SQRT_WAIT: begin
            if (iter_stat.done) begin
               sd_in = iter_quot[rmss_pkg::ROOT_W-1:0];
               if (iter_quot[rmss_pkg::ROOT_W-1:0] == '0) begin
                  snr_in = '0;
                  state_in = rmss_pkg::ST_EMIT;
               end else begin
                  state_in = rmss_pkg::ST_SNR_GO;
               end
            end
         end
         rmss_pkg::ST_SNR_GO: begin
            iter_ctrl.start = 1'b1;
            iter_dividend = rmss_pkg::WIDE_W'({qm_ff, {rmss_pkg::SNR_FRAC{1'b0}}});
            iter_divisor = rmss_pkg::COUNT_W'(sd_ff);
            state_in = rmss_pkg::ST_SNR_WAIT;
         end
         rmss_pkg::ST_SNR_WAIT: begin
            if (iter_stat.done) begin
               if (vs_neg) begin
                  snr_in = (snr_mag > rmss_pkg::SNR_NEG_LIMIT) ? rmss_pkg::SNR_MIN
                           : signed'(rmss_pkg::SNR_W'(-snr_mag));
               end else begin
                  snr_in = (snr_mag > rmss_pkg::SNR_POS_LIMIT) ? rmss_pkg::SNR_MAX
                           : signed'(rmss_pkg::SNR_W'(snr_mag));
               end
               state_in = rmss_pkg::ST_EMIT;
            end
         end
         rmss_pkg::ST_EMIT: begin
            strobe_in = 1'b1;
            out_count_in = roi_count_ff;
            out_empty_in = roi_none;
            if (roi_none) begin
               out_mean_in = '0;
               out_sd_in = '0;
               out_snr_in = '0;
               out_sdz_in = 1'b0;
            end else begin
               out_mean_in = vs_neg ? signed'(rmss_pkg::MEAN_W'(-qm_ff))
                             : signed'(rmss_pkg::MEAN_W'(qm_ff));
               out_sd_in = sd_ff[rmss_pkg::SD_W-1:0];
               out_snr_in = snr_ff;
               out_sdz_in = (sd_ff == '0);
            end
            roi_count_in = '0;
            value_sum_in = '0;
            square_sum_in = '0;
            state_in = rmss_pkg::ST_IDLE;
         end
         default: begin
            state_in = rmss_pkg::ST_IDLE;
         end
      endcase
   end

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_size_ff <= rmss_pkg::X_SIZE_RST;
         y_size_ff <= rmss_pkg::Y_SIZE_RST;
         z_size_ff <= rmss_pkg::Z_SIZE_RST;
         radius_sq_ff <= rmss_pkg::RADIUS_SQ_RST;
         z_low_ff <= rmss_pkg::Z_LOW_RST;
         z_high_ff <= rmss_pkg::Z_HIGH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rmss_pkg::CSR_X_SIZE: x_size_ff <= csr_wdata[rmss_pkg::CFG_SIZE_W-1:0];
            rmss_pkg::CSR_Y_SIZE: y_size_ff <= csr_wdata[rmss_pkg::CFG_SIZE_W-1:0];
            rmss_pkg::CSR_Z_SIZE: z_size_ff <= csr_wdata[rmss_pkg::CFG_SIZE_W-1:0];
            rmss_pkg::CSR_RADIUS_SQ: radius_sq_ff <= csr_wdata[rmss_pkg::RADIUS_W-1:0];
            rmss_pkg::CSR_Z_LOW: z_low_ff <= signed'(csr_wdata[rmss_pkg::Z_W-1:0]);
            rmss_pkg::CSR_Z_HIGH: z_high_ff <= signed'(csr_wdata[rmss_pkg::Z_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmss_pkg::ST_IDLE;
         x_pos_ff <= '0;
         y_pos_ff <= '0;
         z_pos_ff <= '0;
         roi_count_ff <= '0;
         value_sum_ff <= '0;
         square_sum_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         x_pos_ff <= x_pos_in;
         y_pos_ff <= y_pos_in;
         z_pos_ff <= z_pos_in;
         roi_count_ff <= roi_count_in;
         value_sum_ff <= value_sum_in;
         square_sum_ff <= square_sum_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      voxel_ff <= voxel_in;
      mul_ff <= mul_p;
      dist_ff <= dist_in;
      qm_ff <= qm_in;
      rm_ff <= rm_in;
      m_ff <= m_in;
      prod_ff <= prod_in;
      a_ff <= a_in;
      b_ff <= b_in;
      sd_ff <= sd_in;
      snr_ff <= snr_in;
      out_mean_ff <= out_mean_in;
      out_sd_ff <= out_sd_in;
      out_snr_ff <= out_snr_in;
      out_count_ff <= out_count_in;
      out_empty_ff <= out_empty_in;
      out_sdz_ff <= out_sdz_in;
   end

   rmss_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (iter_ctrl),
      .dividend (iter_dividend),
      .divisor  (iter_divisor),
      .stat     (iter_stat),
      .quot     (iter_quot),
      .rem      (iter_rem)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_mean_value = out_mean_ff;
   assign rsp_std_dev = out_sd_ff;
   assign rsp_snr_value = out_snr_ff;
   assign rsp_roi_voxels = out_count_ff;
   assign rsp_roi_empty = out_empty_ff;
   assign rsp_sd_zero = out_sdz_ff;

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("result shown while the block is still busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_roi_empty |-> rsp_roi_voxels == '0 && rsp_mean_value == '0
                                      && rsp_sd_zero == 1'b0)
      else $error("empty ROI transaction carries nonzero fields");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_sd_zero |-> rsp_snr_value == '0)
      else $error("zero deviation with nonzero SNR");
   assert property (@(posedge clock) disable iff (reset)
      iter_ctrl.start |-> !iter_stat.busy)
      else $error("divide/root unit started while busy");
   assert property (@(posedge clock) disable iff (reset)
      roi_count_ff <= rmss_pkg::COUNT_LIMIT)
      else $error("ROI count beyond its limit");
`endif

endmodule
